// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the escape decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, clocked on clk, off in reset
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition must never hold, clocked on clk, off in reset
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// File: rtl/bsed_pkg.sv
// ----------------------------------------------------------------------------
// bsed_pkg
// Types, codes and character constants of the backslash escape decoder.
// ----------------------------------------------------------------------------
package bsed_pkg;

    // Item kinds on the request channel
    localparam logic [1:0] FUNC_DATA = 2'd0;
    localparam logic [1:0] FUNC_SEP  = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DECODE_ESCAPES = 1'b0;
    localparam logic CFG_APPEND_NEWLINE = 1'b1;

    // Octal escapes stop after this many digits, the leading 0 included
    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    // Characters
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Control codes produced by the simple escapes
    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_VT  = 8'd11;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_CR  = 8'd13;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BSL    = 3'd1,
        MODE_HEX0   = 3'd2,
        MODE_HEX1   = 3'd3,
        MODE_OCT    = 3'd4,
        MODE_SUPP   = 3'd5
    } mode_t;

    // Decoder state carried between requests
    typedef struct packed {
        mode_t      mode;
        logic [7:0] value;
        logic [1:0] oct_count;
    } state_t;

    // Up to two result bytes for one request
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.val   = 4'd0;
        if (c >= CH_0 && c <= CH_9)
            h.val = 4'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF)
            h.val = 4'(c - CH_LA + 8'd10);
        else if (c >= CH_UA && c <= CH_UF)
            h.val = 4'(c - CH_UA + 8'd10);
        else
            h.valid = 1'b0;
        return h;
    endfunction

endpackage

// File: rtl/bsed_decode.sv
// ----------------------------------------------------------------------------
// bsed_decode
// Next state and result bytes for one request, purely combinational.
// ----------------------------------------------------------------------------
module bsed_decode (
    input  logic [1:0]       func,
    input  logic [7:0]       in_byte,
    input  logic             decode_escapes,
    input  logic             append_newline,
    input  bsed_pkg::state_t st,
    output bsed_pkg::state_t st_next,
    output bsed_pkg::result_t res
);
    import bsed_pkg::*;

    hex_t       hex;
    logic       plain_bsl;
    logic       is_oct;
    logic [1:0] cnt_inc;
    logic [7:0] oct_val;
    logic       flush_valid;
    logic [7:0] flush_byte;

    assign hex       = hex_digit(in_byte);
    assign plain_bsl = decode_escapes && (in_byte == CH_BSL);
    assign is_oct    = (in_byte >= CH_0) && (in_byte <= CH_7);
    assign cnt_inc   = st.oct_count + 2'd1;
    assign oct_val   = {st.value[4:0], in_byte[2:0]};

    // What a pending escape leaves behind at an argument boundary
    always_comb
    begin
        flush_valid = 1'b1;
        flush_byte  = st.value;
        case (st.mode)
            MODE_BSL:  flush_byte = CH_BSL;
            MODE_HEX0: flush_byte = CH_X;
            MODE_HEX1: flush_byte = st.value;
            MODE_OCT:  flush_byte = st.value;
            default:   flush_valid = 1'b0;
        endcase
    end

    // Main decode
    always_comb
    begin
        st_next   = st;
        res.count = 2'd0;
        res.byte0 = in_byte;
        res.byte1 = in_byte;
        case (func)
            FUNC_DATA:
            begin
                case (st.mode)
                    MODE_BSL:
                    begin
                        st_next.mode = MODE_NORMAL;
                        res.count    = 2'd1;
                        case (in_byte)
                            CH_LA:  res.byte0 = CODE_BEL;
                            CH_LB:  res.byte0 = CODE_BS;
                            CH_LE:  res.byte0 = CH_ESC;
                            CH_LF:  res.byte0 = CODE_FF;
                            CH_LN:  res.byte0 = CH_NL;
                            CH_LR:  res.byte0 = CODE_CR;
                            CH_LT:  res.byte0 = CODE_TAB;
                            CH_LV:  res.byte0 = CODE_VT;
                            CH_BSL: res.byte0 = CH_BSL;
                            CH_C:
                            begin
                                st_next.mode = MODE_SUPP;
                                res.count    = 2'd0;
                            end
                            CH_X:
                            begin
                                st_next.mode  = MODE_HEX0;
                                st_next.value = 8'd0;
                                res.count     = 2'd0;
                            end
                            CH_0:
                            begin
                                st_next.mode      = MODE_OCT;
                                st_next.value     = 8'd0;
                                st_next.oct_count = 2'd1;
                                res.count         = 2'd0;
                            end
                            default:
                            begin
                                // unknown escape: backslash, then the byte
                                res.count = 2'd2;
                                res.byte0 = CH_BSL;
                            end
                        endcase
                    end
                    MODE_HEX0:
                    begin
                        if (hex.valid)
                        begin
                            st_next.mode  = MODE_HEX1;
                            st_next.value = {4'd0, hex.val};
                        end
                        else
                        begin
                            st_next.mode = plain_bsl ? MODE_BSL : MODE_NORMAL;
                            res.count    = plain_bsl ? 2'd1 : 2'd2;
                            res.byte0    = CH_X;
                        end
                    end
                    MODE_HEX1:
                    begin
                        if (hex.valid)
                        begin
                            st_next.mode = MODE_NORMAL;
                            res.count    = 2'd1;
                            res.byte0    = {st.value[3:0], hex.val};
                        end
                        else
                        begin
                            st_next.mode = plain_bsl ? MODE_BSL : MODE_NORMAL;
                            res.count    = plain_bsl ? 2'd1 : 2'd2;
                            res.byte0    = st.value;
                        end
                    end
                    MODE_OCT:
                    begin
                        if (is_oct)
                        begin
                            st_next.value     = oct_val;
                            st_next.oct_count = cnt_inc;
                            if (cnt_inc == OCT_MAX_DIGITS)
                            begin
                                st_next.mode = MODE_NORMAL;
                                res.count    = 2'd1;
                                res.byte0    = oct_val;
                            end
                        end
                        else
                        begin
                            st_next.mode = plain_bsl ? MODE_BSL : MODE_NORMAL;
                            res.count    = plain_bsl ? 2'd1 : 2'd2;
                            res.byte0    = st.value;
                        end
                    end
                    MODE_SUPP:
                    begin
                        st_next.mode = MODE_SUPP;
                    end
                    default:
                    begin
                        st_next.mode = plain_bsl ? MODE_BSL : MODE_NORMAL;
                        res.count    = plain_bsl ? 2'd0 : 2'd1;
                    end
                endcase
            end
            FUNC_SEP:
            begin
                if (st.mode != MODE_SUPP)
                begin
                    st_next.mode = MODE_NORMAL;
                    res.count    = flush_valid ? 2'd2 : 2'd1;
                    res.byte0    = flush_valid ? flush_byte : CH_SPACE;
                    res.byte1    = CH_SPACE;
                end
            end
            FUNC_END:
            begin
                st_next.mode      = MODE_NORMAL;
                st_next.value     = 8'd0;
                st_next.oct_count = 2'd0;
                if (st.mode != MODE_SUPP)
                begin
                    res.count = {1'b0, flush_valid} + {1'b0, append_newline};
                    res.byte0 = flush_valid ? flush_byte : CH_NL;
                    res.byte1 = CH_NL;
                end
            end
            default:
            begin
                // unused code: no results, state kept
                st_next = st;
            end
        endcase
    end

endmodule

// File: rtl/backslash_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top
// Echo-style backslash escape decoder with a two-entry result buffer.
// ----------------------------------------------------------------------------
// A request is decoded in the cycle it is accepted and its result bytes
// (none, one or two) land in a two-entry result buffer that drives the output
// port. A request that yields at most one byte can be followed by another in
// the next cycle, provided that byte is taken in that same cycle; while the
// byte waits, the input is held off. One that yields two bytes holds the
// input off until its first byte is taken, since the single output port
// drains one byte per cycle while out_ready is high. Register writes take
// effect at the next edge; no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module backslash_escape_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data,
    // request channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] in_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);
    import bsed_pkg::*;

    logic       decode_escapes_reg;
    logic       append_newline_reg;
    state_t     st_reg;
    state_t     st_next;
    result_t    res;
    logic [7:0] slot0_reg;
    logic [7:0] slot1_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       in_fire;
    logic       out_fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_escapes_reg <= 1'b0;
            append_newline_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECODE_ESCAPES: decode_escapes_reg <= cfg_data;
                CFG_APPEND_NEWLINE: append_newline_reg <= cfg_data;
                default:            decode_escapes_reg <= decode_escapes_reg;
            endcase
        end
    end

    // Decode
    bsed_decode u_decode (
        .func           (func),
        .in_byte        (in_byte),
        .decode_escapes (decode_escapes_reg),
        .append_newline (append_newline_reg),
        .st             (st_reg),
        .st_next        (st_next),
        .res            (res)
    );

    // Handshakes: accept when the buffer is empty or empties this cycle
    assign out_valid = (fill_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (fill_reg == 2'd0) || ((fill_reg == 2'd1) && out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_byte  = slot0_reg;
    assign last      = (fill_reg == 2'd1);

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode      <= MODE_NORMAL;
            st_reg.value     <= 8'd0;
            st_reg.oct_count <= 2'd0;
        end
        else if (in_fire)
        begin
            st_reg <= st_next;
        end
    end

    // Result buffer occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (in_fire)
            fill_next = res.count;
        else if (out_fire)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= fill_next;
    end

    // Result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot0_reg <= res.byte0;
            slot1_reg <= res.byte1;
        end
        else if (out_fire)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    // Checks
    `ASSERT_NEVER(a_fill_range, fill_reg == 2'd3)
    `ASSERT_IMPLY(a_full_blocks_input, fill_reg == 2'd2, !in_ready)
    `ASSERT_IMPLY(a_supp_silent, in_fire && (st_reg.mode == MODE_SUPP), res.count == 2'd0)
    `ASSERT_IMPLY(a_oct_count_live, st_reg.mode == MODE_OCT,
                  (st_reg.oct_count == 2'd1) || (st_reg.oct_count == 2'd2))

endmodule

// File: test/tb_backslash_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_backslash_escape_decoder_top
// Self-checking bench for the echo-style backslash escape decoder.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver. Each accepted request
// runs through a local decoder that predicts the output bytes and their last
// flags. A clocked monitor compares every output byte with the oldest
// prediction. A short directed run is followed by random well-formed escape
// sequences mixed with noise, over several register settings and idle
// profiles, with one long receiver hold-off to fill the result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_backslash_escape_decoder_top;

    import bsed_pkg::*;

    // Unused request kind, ignored by the block
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int CHUNK_ITEMS = 125;
    localparam int NUM_PHASES  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 30;

    typedef struct {
        logic [1:0] f;
        logic [7:0] b;
    } request_t;

    typedef struct {
        logic [7:0] val;
        logic       fin;
    } out_char_t;

    // DUT signals; the driven inputs are known from time zero
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = 1'b0;
    logic       cfg_data  = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] func      = FUNC_DATA;
    logic [7:0] in_byte   = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last;

    // Request and prediction stores
    request_t  request_q[$];
    out_char_t expected_chars[$];
    logic [7:0] decoded_now[$];

    // Local decoder state and register copies
    mode_t      dec_mode    = MODE_NORMAL;
    logic [7:0] esc_val     = 8'd0;
    logic [1:0] oct_cnt     = 2'd0;
    logic       cfg_decode  = 1'b0;
    logic       cfg_newline = 1'b1;

    // Idle profiles and the hold-off trigger
    int   snd_idle_pct = 9;
    int   rcv_idle_pct = 63;
    logic hold_armed   = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;

    int error_count = 0;
    int chunk_items = 0;
    int stall_count = 0;

    string hex_chars    = "0123456789abcdefABCDEF";
    string simple_chars = "abefnrtv\\";

    // Phase plans: register settings per chunk
    logic plan_decode[NUM_PHASES]  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    logic plan_newline[NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    backslash_escape_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------------
    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF)
            return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // A byte outside any escape: may open a new one
    task automatic plain_char(input logic [7:0] b);
        if (cfg_decode && b == CH_BSL)
            dec_mode = MODE_BSL;
        else
            decoded_now.push_back(b);
    endtask

    // Emit whatever an unfinished escape stands for
    task automatic flush_escape();
        case (dec_mode)
            MODE_BSL:           decoded_now.push_back(CH_BSL);
            MODE_HEX0:          decoded_now.push_back(CH_X);
            MODE_HEX1, MODE_OCT: decoded_now.push_back(esc_val);
            default:            ;
        endcase
        dec_mode = MODE_NORMAL;
    endtask

    task automatic decode_request(input logic [1:0] f, input logic [7:0] b);
        int hv;
        out_char_t oc;
        decoded_now.delete();
        case (f)
            FUNC_DATA:
            begin
                case (dec_mode)
                    MODE_BSL:
                    begin
                        dec_mode = MODE_NORMAL;
                        case (b)
                            CH_LA:  decoded_now.push_back(CODE_BEL);
                            CH_LB:  decoded_now.push_back(CODE_BS);
                            CH_LE:  decoded_now.push_back(CH_ESC);
                            CH_LF:  decoded_now.push_back(CODE_FF);
                            CH_LN:  decoded_now.push_back(CH_NL);
                            CH_LR:  decoded_now.push_back(CODE_CR);
                            CH_LT:  decoded_now.push_back(CODE_TAB);
                            CH_LV:  decoded_now.push_back(CODE_VT);
                            CH_BSL: decoded_now.push_back(CH_BSL);
                            CH_C:   dec_mode = MODE_SUPP;
                            CH_X:
                            begin
                                dec_mode = MODE_HEX0;
                                esc_val  = 8'd0;
                            end
                            CH_0:
                            begin
                                dec_mode = MODE_OCT;
                                esc_val  = 8'd0;
                                oct_cnt  = 2'd1;
                            end
                            default:
                            begin
                                // unknown escape keeps its backslash
                                decoded_now.push_back(CH_BSL);
                                decoded_now.push_back(b);
                            end
                        endcase
                    end
                    MODE_HEX0:
                    begin
                        hv = hex_value(b);
                        if (hv >= 0)
                        begin
                            esc_val  = 8'(hv);
                            dec_mode = MODE_HEX1;
                        end
                        else
                        begin
                            dec_mode = MODE_NORMAL;
                            decoded_now.push_back(CH_X);
                            plain_char(b);
                        end
                    end
                    MODE_HEX1:
                    begin
                        hv = hex_value(b);
                        dec_mode = MODE_NORMAL;
                        if (hv >= 0)
                            decoded_now.push_back({esc_val[3:0], 4'(hv)});
                        else
                        begin
                            decoded_now.push_back(esc_val);
                            plain_char(b);
                        end
                    end
                    MODE_OCT:
                    begin
                        if (b >= CH_0 && b <= CH_7)
                        begin
                            esc_val = {esc_val[4:0], b[2:0]};
                            oct_cnt = oct_cnt + 2'd1;
                            if (oct_cnt >= OCT_MAX_DIGITS)
                            begin
                                dec_mode = MODE_NORMAL;
                                decoded_now.push_back(esc_val);
                            end
                        end
                        else
                        begin
                            dec_mode = MODE_NORMAL;
                            decoded_now.push_back(esc_val);
                            plain_char(b);
                        end
                    end
                    MODE_SUPP: ;
                    default:
                    begin
                        dec_mode = MODE_NORMAL;
                        plain_char(b);
                    end
                endcase
            end
            FUNC_SEP:
            begin
                if (dec_mode != MODE_SUPP)
                begin
                    flush_escape();
                    decoded_now.push_back(CH_SPACE);
                end
            end
            FUNC_END:
            begin
                if (dec_mode == MODE_SUPP)
                    dec_mode = MODE_NORMAL;
                else
                begin
                    flush_escape();
                    if (cfg_newline)
                        decoded_now.push_back(CH_NL);
                end
                esc_val = 8'd0;
                oct_cnt = 2'd0;
            end
            default: ;
        endcase
        foreach (decoded_now[i])
        begin
            oc.val = decoded_now[i];
            oc.fin = (i == decoded_now.size() - 1);
            expected_chars.push_back(oc);
        end
    endtask

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic     nxt_valid;
        request_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= FUNC_DATA;
            in_byte  <= 8'd0;
        end
        else
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                decode_request(func, in_byte);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && request_q.size() != 0 &&
                $urandom_range(99) >= snd_idle_pct)
            begin
                req = request_q.pop_front();
                func      <= req.f;
                in_byte   <= req.b;
                nxt_valid = 1'b1;
            end
            in_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with random back-pressure and one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        out_char_t exp_c;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                    report_error($sformatf("unexpected byte %02h", out_byte));
                else
                begin
                    exp_c = expected_chars.pop_front();
                    if (out_byte !== exp_c.val)
                        report_error($sformatf("byte %02h, wanted %02h",
                                               out_byte, exp_c.val));
                    if (last !== exp_c.fin)
                        report_error($sformatf("last %b, wanted %b on byte %02h",
                                               last, exp_c.fin, exp_c.val));
                end
            end
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [1:0] f, input logic [7:0] b);
        request_t req;
        req.f = f;
        req.b = b;
        request_q.push_back(req);
        if (f != FUNC_UNUSED)
            chunk_items++;
    endtask

    // Wait until every request is in and every byte out, then let it settle
    task automatic wait_idle(input int settle);
        while (request_q.size() != 0 || in_valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DECODE_ESCAPES)
            cfg_decode = val;
        else
            cfg_newline = val;
    endtask

    // One random token: plain bytes, escapes, separators, ends and some noise
    task automatic gen_token();
        int pick;
        int ndig;
        pick = $urandom_range(99);
        if (pick < 25)
            push_item(FUNC_DATA, 8'($urandom_range(32, 126)));
        else if (pick < 35)
            push_item(FUNC_DATA, 8'($urandom));
        else if (pick < 55)
        begin
            push_item(FUNC_DATA, CH_BSL);
            if ($urandom_range(4) == 0)
                push_item(FUNC_DATA, 8'($urandom));
            else
                push_item(FUNC_DATA, simple_chars[$urandom_range(8)]);
        end
        else if (pick < 67)
        begin
            push_item(FUNC_DATA, CH_BSL);
            push_item(FUNC_DATA, CH_X);
            ndig = $urandom_range(2);
            repeat (ndig) push_item(FUNC_DATA, hex_chars[$urandom_range(21)]);
        end
        else if (pick < 79)
        begin
            push_item(FUNC_DATA, CH_BSL);
            push_item(FUNC_DATA, CH_0);
            ndig = $urandom_range(3);
            repeat (ndig) push_item(FUNC_DATA, 8'(CH_0 + $urandom_range(7)));
        end
        else if (pick < 81)
        begin
            push_item(FUNC_DATA, CH_BSL);
            push_item(FUNC_DATA, CH_C);
        end
        else if (pick < 89)
            push_item(FUNC_SEP, 8'($urandom));
        else if (pick < 97)
            push_item(FUNC_END, 8'($urandom));
        else if (pick < 99)
            push_item(FUNC_DATA, CH_BSL);
        else
            push_item(FUNC_UNUSED, 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: bytes pass literally, extremes and the unused code
        @(negedge clk);
        push_item(FUNC_DATA, CH_BSL);
        push_item(FUNC_DATA, 8'h00);
        push_item(FUNC_DATA, 8'hFF);
        push_item(FUNC_UNUSED, 8'hA5);
        push_item(FUNC_END, 8'h5A);
        wait_idle(4);

        // Escapes on: hex, flushes, octal limit, suppression
        write_reg(CFG_DECODE_ESCAPES, 1'b1);
        @(negedge clk);
        push_item(FUNC_DATA, CH_BSL);
        push_item(FUNC_DATA, CH_X);
        push_item(FUNC_DATA, 8'h34);
        push_item(FUNC_DATA, 8'h31);
        // hex escape with no digit at the end of the message
        push_item(FUNC_DATA, CH_BSL);
        push_item(FUNC_DATA, CH_X);
        push_item(FUNC_END, 8'h00);
        // octal escape stops after three digits, the fourth is plain
        push_item(FUNC_DATA, CH_BSL);
        push_item(FUNC_DATA, CH_0);
        push_item(FUNC_DATA, 8'h31);
        push_item(FUNC_DATA, 8'h32);
        push_item(FUNC_DATA, 8'h33);
        // suppressed output up to the end of the message
        push_item(FUNC_DATA, CH_BSL);
        push_item(FUNC_DATA, CH_C);
        push_item(FUNC_DATA, CH_LA);
        push_item(FUNC_SEP, 8'hFF);
        push_item(FUNC_END, 8'hFF);
        // lone backslash flushed by a separator
        push_item(FUNC_DATA, CH_BSL);
        push_item(FUNC_SEP, 8'h00);

        // Random phases over register settings and idle profiles
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle(4);
            write_reg(CFG_DECODE_ESCAPES, plan_decode[ph]);
            write_reg(CFG_APPEND_NEWLINE, plan_newline[ph]);
            @(posedge clk);
            if (ph < 3)
            begin
                snd_idle_pct <= 9;
                rcv_idle_pct <= 63;
            end
            else if (ph < 6)
            begin
                snd_idle_pct <= 63;
                rcv_idle_pct <= 9;
            end
            else
            begin
                snd_idle_pct <= 0;
                rcv_idle_pct <= 0;
            end
            if (ph == 6)
                hold_armed <= 1'b1;
            @(negedge clk);
            chunk_items = 0;
            while (chunk_items < CHUNK_ITEMS)
                gen_token();
        end

        wait_idle(20);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bsed_pkg.sv
rtl/bsed_decode.sv
rtl/backslash_escape_decoder_top.sv
test/tb_backslash_escape_decoder_top.sv
